// ===== src/utf8_validating_escape_filter_defines.svh =====
// Assertion macros shared by the filter's modules.
`ifndef UTF8_VALIDATING_ESCAPE_FILTER_DEFINES_SVH
`define UTF8_VALIDATING_ESCAPE_FILTER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define UVEF_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("uvef assertion failed");

// Next-cycle implication, checked outside reset.
`define UVEF_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("uvef assertion failed");

`endif

// ===== src/uvef_pkg.sv =====
// Types, constants and decode functions of the UTF-8 escape filter.
package uvef_pkg;

  // One unit of work handed from the front to the back.
  typedef struct packed {
    logic            trunc;
    logic            last;
    logic [2:0]      len;
    logic [3:0][7:0] b;
  } seg_t;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  localparam logic [7:0] CH_BSL = 8'h5C;

  // Length of the sequence at b[0]: 1 to 4, or 0 while more bytes are needed.
  function automatic logic [2:0] decide(logic [3:0][7:0] b, logic [2:0] n, logic e);
    logic [2:0] need;
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] lead;
    logic [2:0] res;
    lead = b[0];
    lo   = 8'h80;
    hi   = 8'hBF;
    need = 3'd1;
    if (lead >= 8'hC2 && lead <= 8'hDF) need = 3'd2;
    else if (lead >= 8'hE0 && lead <= 8'hEF) need = 3'd3;
    else if (lead >= 8'hF0 && lead <= 8'hF4) need = 3'd4;
    if (lead == 8'hE0) lo = 8'hA0;
    if (lead == 8'hED) hi = 8'h9F;
    if (lead == 8'hF0) lo = 8'h90;
    if (lead == 8'hF4) hi = 8'h8F;
    if (need == 3'd1) res = 3'd1;
    else if (n > 3'd1 && (b[1] < lo || b[1] > hi)) res = 3'd1;
    else if (n > 3'd2 && need > 3'd2 && (b[2] < 8'h80 || b[2] > 8'hBF)) res = 3'd1;
    else if (n > 3'd3 && need > 3'd3 && (b[3] < 8'h80 || b[3] > 8'hBF)) res = 3'd1;
    else if (n >= need) res = need;
    else res = e ? 3'd1 : 3'd0;
    return res;
  endfunction

  function automatic logic [7:0] hex_digit(logic [3:0] v);
    return (v < 4'd10) ? (8'h30 + {4'd0, v}) : (8'h37 + {4'd0, v});
  endfunction

  function automatic logic [20:0] code_point(seg_t s);
    logic [20:0] cp;
    case (s.len)
      3'd2:    cp = {10'd0, s.b[0][4:0], s.b[1][5:0]};
      3'd3:    cp = {5'd0, s.b[0][3:0], s.b[1][5:0], s.b[2][5:0]};
      3'd4:    cp = {s.b[0][2:0], s.b[1][5:0], s.b[2][5:0], s.b[3][5:0]};
      default: cp = {13'd0, s.b[0]};
    endcase
    return cp;
  endfunction

  function automatic logic is_uesc(logic [20:0] cp);
    return (cp >= 21'h80 && cp <= 21'h9F) || cp == 21'h061C || cp == 21'h200E ||
           cp == 21'h200F || (cp >= 21'h202A && cp <= 21'h202E) ||
           (cp >= 21'h2066 && cp <= 21'h2069);
  endfunction

  // Number of output characters for one unit of work.
  function automatic logic [3:0] char_count(seg_t s);
    logic [20:0] cp;
    logic [3:0]  c;
    cp = code_point(s);
    if (s.trunc) c = 4'd14;
    else if (s.len == 3'd1 && (s.b[0] == 8'h0A || s.b[0] == 8'h0D || s.b[0] == 8'h09))
      c = 4'd2;
    else if (s.len == 3'd1 && (s.b[0] < 8'h20 || s.b[0] >= 8'h7F)) c = 4'd4;
    else if (is_uesc(cp)) c = 4'd6;
    else c = {1'b0, s.len};
    return c;
  endfunction

  // Output character at position idx of one unit of work.
  function automatic logic [7:0] char_at(seg_t s, logic [3:0] idx);
    logic [20:0] cp;
    logic [7:0]  ch;
    cp = code_point(s);
    if (s.trunc) begin
      case (idx)
        4'd0, 4'd1, 4'd2: ch = 8'h2E;
        4'd3:  ch = 8'h5B;
        4'd4:  ch = 8'h74;
        4'd5:  ch = 8'h72;
        4'd6:  ch = 8'h75;
        4'd7:  ch = 8'h6E;
        4'd8:  ch = 8'h63;
        4'd9:  ch = 8'h61;
        4'd10: ch = 8'h74;
        4'd11: ch = 8'h65;
        4'd12: ch = 8'h64;
        default: ch = 8'h5D;
      endcase
    end else if (s.len == 3'd1 && (s.b[0] == 8'h0A || s.b[0] == 8'h0D || s.b[0] == 8'h09))
    begin
      if (idx == 4'd0) ch = CH_BSL;
      else if (s.b[0] == 8'h0A) ch = 8'h6E;
      else if (s.b[0] == 8'h0D) ch = 8'h72;
      else ch = 8'h74;
    end else if (s.len == 3'd1 && (s.b[0] < 8'h20 || s.b[0] >= 8'h7F)) begin
      case (idx)
        4'd0:    ch = CH_BSL;
        4'd1:    ch = 8'h78;
        4'd2:    ch = hex_digit(s.b[0][7:4]);
        default: ch = hex_digit(s.b[0][3:0]);
      endcase
    end else if (is_uesc(cp)) begin
      case (idx)
        4'd0:    ch = CH_BSL;
        4'd1:    ch = 8'h75;
        4'd2:    ch = hex_digit(cp[15:12]);
        4'd3:    ch = hex_digit(cp[11:8]);
        4'd4:    ch = hex_digit(cp[7:4]);
        default: ch = hex_digit(cp[3:0]);
      endcase
    end else begin
      ch = s.b[idx[1:0]];
    end
    return ch;
  endfunction

endpackage

// ===== src/uvef_front.sv =====
// Front part: takes bytes, decodes UTF-8 and applies the byte limit.
`include "utf8_validating_escape_filter_defines.svh"
module uvef_front #(
  parameter int OFFSET_BITS = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [7:0]      in_tdata,
  input  logic            in_tlast,
  input  logic            cfg_wr_en,
  input  logic            cfg_index,
  input  logic [15:0]     cfg_wdata,
  output logic            q_push,
  output uvef_pkg::seg_t  q_seg,
  input  logic            q_full
);

  localparam int OW = OFFSET_BITS + 1;
  localparam int CW = (OFFSET_BITS + 2 > 17) ? OFFSET_BITS + 2 : 17;
  localparam logic [CW-1:0] OFF_MAX = CW'((64'd1 << OW) - 64'd1);

  logic [3:0][7:0] buf_r, buf_nxt;
  logic [2:0]      n_r, n_nxt;
  logic            end_r, end_nxt;
  logic            active_r, active_nxt;
  logic [OW-1:0]   off_r, off_nxt;
  logic            trunc_r, trunc_nxt;
  logic [15:0]     limit_r;
  logic            nolim_r;

  logic [CW-1:0]   off_x, lim_x, sum_x, off_s;
  logic [2:0]      len, nn;
  logic [3:0][7:0] nb;
  logic            can_step, over, more, finish, acc;

  // One decision of the decoder per cycle while the queue is not full, with a look at the next one.
  always_comb begin
    off_x    = CW'(off_r);
    lim_x    = CW'(limit_r);
    can_step = active_r && !q_full;
    len      = uvef_pkg::decide(buf_r, n_r, end_r);
    sum_x    = off_x + CW'(len);
    off_s    = (sum_x > OFF_MAX) ? OFF_MAX : sum_x;
    nb       = buf_r >> ({3'd0, len} * 6'd8);
    nn       = n_r - len;
    over     = !nolim_r && ((off_x >= lim_x) || (len != 3'd0 && sum_x > lim_x));
    more     = (nn != 3'd0) && ((!nolim_r && off_s >= lim_x) ||
               (uvef_pkg::decide(nb, nn, end_r) != 3'd0));
    finish   = over || len == 3'd0 || !more;
    q_push   = can_step && (over || len != 3'd0);
    q_seg.trunc = over;
    q_seg.last  = over || !more;
    q_seg.len   = len;
    q_seg.b     = buf_r;
    in_tready   = !active_r || (can_step && finish);
    acc         = in_tvalid && in_tready;

    buf_nxt    = buf_r;
    n_nxt      = n_r;
    end_nxt    = end_r;
    active_nxt = active_r;
    off_nxt    = off_r;
    trunc_nxt  = trunc_r;
    if (can_step) begin
      if (over) begin
        trunc_nxt = 1'b1;
        n_nxt     = 3'd0;
      end else if (len != 3'd0) begin
        buf_nxt = nb;
        n_nxt   = nn;
        off_nxt = off_s[OW-1:0];
      end
      if (finish) begin
        active_nxt = 1'b0;
        if (end_r) begin
          n_nxt     = 3'd0;
          off_nxt   = '0;
          trunc_nxt = 1'b0;
        end
      end
    end
    // A new byte joins whatever the step above left pending.
    if (acc) begin
      if (trunc_nxt) begin
        if (in_tlast) begin
          n_nxt     = 3'd0;
          off_nxt   = '0;
          trunc_nxt = 1'b0;
        end
      end else begin
        buf_nxt[n_nxt[1:0]] = in_tdata;
        n_nxt      = n_nxt + 3'd1;
        end_nxt    = in_tlast;
        active_nxt = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r      <= 3'd0;
      end_r    <= 1'b0;
      active_r <= 1'b0;
      off_r    <= '0;
      trunc_r  <= 1'b0;
      limit_r  <= 16'd256;
      nolim_r  <= 1'b0;
    end else begin
      n_r      <= n_nxt;
      end_r    <= end_nxt;
      active_r <= active_nxt;
      off_r    <= off_nxt;
      trunc_r  <= trunc_nxt;
      if (cfg_wr_en && cfg_index == 1'b0) limit_r <= cfg_wdata;
      if (cfg_wr_en && cfg_index == 1'b1) nolim_r <= cfg_wdata[0];
    end
  end

  // Pending bytes.
  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
  end

  `UVEF_ASSERT_IMP(a_pend_fits, !active_r, n_r <= 3'd3)
  `UVEF_ASSERT_IMP(a_trunc_idle, trunc_r, !active_r)
  `UVEF_ASSERT_NXT(a_trunc_clears, can_step && over && end_r, !trunc_r)

endmodule

// ===== src/uvef_queue.sv =====
// Short queue of work units between the front and the back.
`include "utf8_validating_escape_filter_defines.svh"
module uvef_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  uvef_pkg::seg_t push_seg,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output uvef_pkg::seg_t head
);

  uvef_pkg::seg_t                  mem_r [uvef_pkg::QDEPTH];
  logic [uvef_pkg::QPTR_W-1:0]     wp_r, rp_r;
  logic [uvef_pkg::QCNT_W-1:0]     cnt_r, cnt_nxt;

  assign full  = cnt_r == uvef_pkg::QCNT_W'(uvef_pkg::QDEPTH);
  assign valid = cnt_r != '0;
  assign head  = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r + uvef_pkg::QCNT_W'(push) - uvef_pkg::QCNT_W'(pop);
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + uvef_pkg::QPTR_W'(1);
      if (pop) rp_r <= rp_r + uvef_pkg::QPTR_W'(1);
      cnt_r <= cnt_nxt;
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_seg;
  end

  `UVEF_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= uvef_pkg::QCNT_W'(uvef_pkg::QDEPTH))

endmodule

// ===== src/uvef_back.sv =====
// Back part: expands work units into output characters.
`include "utf8_validating_escape_filter_defines.svh"
module uvef_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  uvef_pkg::seg_t q_head,
  output logic           q_pop,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [7:0]     out_tdata,
  output logic           out_tlast
);

  logic [3:0] idx_r, idx_nxt, cnt;
  logic       out_tvalid_r, load, at_end;
  logic [7:0] out_tdata_r;
  logic       out_tlast_r;

  // Next character of the head unit.
  always_comb begin
    cnt     = uvef_pkg::char_count(q_head);
    at_end  = idx_r == cnt - 4'd1;
    load    = q_valid && (!out_tvalid_r || out_tready);
    q_pop   = load && at_end;
    idx_nxt = idx_r;
    if (load) idx_nxt = at_end ? 4'd0 : idx_r + 4'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r        <= 4'd0;
      out_tvalid_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      if (load) out_tvalid_r <= 1'b1;
      else if (out_tready) out_tvalid_r <= 1'b0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (load) begin
      out_tdata_r <= uvef_pkg::char_at(q_head, idx_r);
      out_tlast_r <= q_head.last && at_end;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  `UVEF_ASSERT_IMP(a_idle_idx, !q_valid, idx_r == 4'd0)

endmodule

// ===== src/utf8_validating_escape_filter.sv =====
// Top level of the UTF-8 validating escape filter.
// Throughput: one input byte per cycle for unescaped text while out_tready holds; an escape
// gives 2, 4 or 6 output characters and the truncation marker 14, one character a cycle.
// Path: an accepted byte passes the front's pending buffer, the queue and the output register.
// A malformed prefix makes the front examine its later bytes again.
// Reset is synchronous, active low: limit 256, truncation enabled, state empty.
module utf8_validating_escape_filter #(
  parameter int OFFSET_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // text_byte
  input  logic        in_tlast,   // end_of_text
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // out_char
  output logic        out_tlast,  // run_last
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);

  logic           push, full, pop, qv;
  uvef_pkg::seg_t push_seg, head;

  uvef_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .cfg_wr_en, .cfg_index, .cfg_wdata,
    .q_push(push), .q_seg(push_seg), .q_full(full)
  );

  uvef_queue u_queue (
    .clk, .rst_n, .push, .push_seg, .full, .pop, .valid(qv), .head
  );

  uvef_back u_back (
    .clk, .rst_n, .q_valid(qv), .q_head(head), .q_pop(pop),
    .out_tvalid, .out_tready, .out_tdata, .out_tlast
  );

endmodule

// ===== sim/utf8_validating_escape_filter_tb.sv =====
// Self-checking testbench of the UTF-8 validating escape filter.
`timescale 1ns / 1ps

module utf8_validating_escape_filter_tb;

  localparam int OFFSET_BITS = 16;
  localparam logic [16:0] OFS_SAT = 17'h1FFFF;
  localparam logic REG_LIMIT = 1'b0;
  localparam logic REG_NOLIM = 1'b1;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic        cfg_wr_en;
  logic        cfg_index;
  logic [15:0] cfg_wdata;

  utf8_validating_escape_filter #(.OFFSET_BITS(OFFSET_BITS)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_t;

  // Shadow of the filter state and registers.
  logic [7:0]  held [3];
  int          held_n;
  logic [16:0] ofs;
  logic        trunc_done;
  logic [15:0] lim;
  logic        nolim;

  char_t expected_chars[$];
  int    errors;
  bit    idle_free;
  bit    rx_hold;
  bit    hold_go;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("FAIL utf8_validating_escape_filter");
    $finish;
  end

  function automatic logic [7:0] hexch(logic [3:0] v);
    return (v < 4'd10) ? 8'h30 + {4'd0, v} : 8'h37 + {4'd0, v};
  endfunction

  function automatic int seq_len(logic [7:0] b [4], int n, bit fin);
    int need;
    logic [7:0] lo, hi;
    lo = 8'h80;
    hi = 8'hBF;
    if (b[0] < 8'h80) return 1;
    if (b[0] >= 8'hC2 && b[0] <= 8'hDF) need = 2;
    else if (b[0] >= 8'hE0 && b[0] <= 8'hEF) need = 3;
    else if (b[0] >= 8'hF0 && b[0] <= 8'hF4) need = 4;
    else return 1;
    if (b[0] == 8'hE0) lo = 8'hA0;
    if (b[0] == 8'hED) hi = 8'h9F;
    if (b[0] == 8'hF0) lo = 8'h90;
    if (b[0] == 8'hF4) hi = 8'h8F;
    for (int i = 1; i < ((n < need) ? n : need); i++) begin
      if (b[i] < ((i == 1) ? lo : 8'h80) || b[i] > ((i == 1) ? hi : 8'hBF)) return 1;
    end
    if (n >= need) return need;
    return fin ? 1 : 0;
  endfunction

  task automatic push_char(logic [7:0] c);
    expected_chars.push_back('{ch: c, last: 1'b0});
  endtask

  task automatic push_marker();
    string m;
    m = "...[truncated]";
    for (int i = 0; i < m.len(); i++) push_char(m[i]);
  endtask

  task automatic push_shown(logic [7:0] b [4], int len);
    logic [20:0] cp;
    case (len)
      2: cp = {10'd0, b[0][4:0], b[1][5:0]};
      3: cp = {5'd0, b[0][3:0], b[1][5:0], b[2][5:0]};
      4: cp = {b[0][2:0], b[1][5:0], b[2][5:0], b[3][5:0]};
      default: cp = {13'd0, b[0]};
    endcase
    if (len == 1 && (b[0] == 8'h0A || b[0] == 8'h0D || b[0] == 8'h09)) begin
      push_char(8'h5C);
      push_char(b[0] == 8'h0A ? 8'h6E : b[0] == 8'h0D ? 8'h72 : 8'h74);
    end else if (len == 1 && (b[0] < 8'h20 || b[0] >= 8'h7F)) begin
      push_char(8'h5C); push_char(8'h78);
      push_char(hexch(b[0][7:4])); push_char(hexch(b[0][3:0]));
    end else if ((cp >= 21'h80 && cp <= 21'h9F) || cp == 21'h61C || cp == 21'h200E ||
                 cp == 21'h200F || (cp >= 21'h202A && cp <= 21'h202E) ||
                 (cp >= 21'h2066 && cp <= 21'h2069)) begin
      push_char(8'h5C); push_char(8'h75);
      for (int i = 3; i >= 0; i--) push_char(hexch(cp[4*i +: 4]));
    end else begin
      for (int i = 0; i < len; i++) push_char(b[i]);
    end
  endtask

  // Predicts the characters caused by one accepted text byte.
  task automatic predict_text_byte(logic [7:0] tb, logic fin);
    logic [7:0] b [4];
    int n, len, base_cnt;
    base_cnt = expected_chars.size();
    if (!trunc_done) begin
      n = held_n;
      for (int i = 0; i < n; i++) b[i] = held[i];
      b[n++] = tb;
      while (n > 0) begin
        if (!nolim && ofs >= lim) begin
          push_marker(); trunc_done = 1'b1; n = 0; break;
        end
        len = seq_len(b, n, fin);
        if (len == 0) break;
        if (!nolim && ofs + len > lim) begin
          push_marker(); trunc_done = 1'b1; n = 0; break;
        end
        push_shown(b, len);
        ofs = (ofs + len > OFS_SAT) ? OFS_SAT : 17'(ofs + len);
        for (int i = 0; i < n - len; i++) b[i] = b[i + len];
        n -= len;
      end
      if (n > 3) n = 3;
      for (int i = 0; i < n; i++) held[i] = b[i];
      held_n = n;
    end
    if (fin) begin
      held_n = 0; ofs = '0; trunc_done = 1'b0;
    end
    if (expected_chars.size() > base_cnt)
      expected_chars[expected_chars.size() - 1].last = 1'b1;
  endtask

  // Result checker and receiver stall.
  always @(posedge clk) begin
    char_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected out_char 0x%02h", out_tdata);
        errors++;
      end else begin
        e = expected_chars.pop_front();
        if (out_tdata !== e.ch) begin
          $error("out_char expected 0x%02h actual 0x%02h", e.ch, out_tdata);
          errors++;
        end
        if (out_tlast !== e.last) begin
          $error("run_last expected %0d actual %0d", e.last, out_tlast);
          errors++;
        end
      end
    end
    out_tready <= !rx_hold && (idle_free || $urandom_range(99) >= 35);
  end

  // The receiver holds off for a long stretch while requests keep coming.
  initial begin
    rx_hold = 1'b0;
    wait (rst_n);
    wait (hold_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (400) @(posedge clk);
    rx_hold <= 1'b0;
  end

  task automatic cfg_write(logic idx, logic [15:0] val);
    cfg_wr_en <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_LIMIT) lim = val; else nolim = val[0];
    @(posedge clk);
  endtask

  // Offers one request and waits for its acceptance.
  task automatic send_byte(logic [7:0] tb, logic fin);
    while (!idle_free && $urandom_range(99) < 35) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1; in_tdata <= tb; in_tlast <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_text_byte(tb, fin);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_chars.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_cont();
    return 8'h80 | 8'($urandom_range(63));
  endfunction

  // Directed table: byte, end mark, and the first expected character where obvious.
  typedef struct { logic [7:0] b; logic fin; logic chk; logic [7:0] first; } row_t;
  row_t dir_tab [$] = '{
    '{8'h41, 1'b0, 1'b1, 8'h41}, '{8'h0A, 1'b0, 1'b1, 8'h5C}, '{8'h0D, 1'b0, 1'b1, 8'h5C},
    '{8'h09, 1'b0, 1'b1, 8'h5C}, '{8'h01, 1'b0, 1'b1, 8'h5C}, '{8'h7F, 1'b0, 1'b1, 8'h5C},
    '{8'hFF, 1'b0, 1'b1, 8'h5C}, '{8'hC2, 1'b0, 1'b0, 8'h00}, '{8'h85, 1'b0, 1'b0, 8'h00},
    '{8'hE2, 1'b0, 1'b0, 8'h00}, '{8'h80, 1'b0, 1'b0, 8'h00}, '{8'hAE, 1'b0, 1'b0, 8'h00},
    '{8'hE0, 1'b0, 1'b0, 8'h00}, '{8'h80, 1'b0, 1'b0, 8'h00}, '{8'hED, 1'b0, 1'b0, 8'h00},
    '{8'hA0, 1'b0, 1'b0, 8'h00}, '{8'hF4, 1'b0, 1'b0, 8'h00}, '{8'h90, 1'b0, 1'b0, 8'h00},
    '{8'hF0, 1'b0, 1'b0, 8'h00}, '{8'h9F, 1'b0, 1'b0, 8'h00}, '{8'h98, 1'b0, 1'b0, 8'h00},
    '{8'h80, 1'b0, 1'b0, 8'h00}, '{8'hE4, 1'b0, 1'b0, 8'h00}, '{8'hB8, 1'b1, 1'b0, 8'h00}
  };

  initial begin
    logic [7:0] lead;
    errors = 0; idle_free = 1'b0;
    rst_n = 1'b0; in_tvalid = 1'b0; in_tdata = '0; in_tlast = 1'b0;
    out_tready = 1'b0; cfg_wr_en = 1'b0; cfg_index = REG_LIMIT; cfg_wdata = '0;
    held_n = 0; ofs = '0; trunc_done = 1'b0; lim = 16'd256; nolim = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      send_byte(dir_tab[i].b, dir_tab[i].fin);
      if (dir_tab[i].chk && expected_chars.size() > 0 &&
          expected_chars[expected_chars.size() - 1 - (dir_tab[i].b == 8'h41 ? 0 :
            (dir_tab[i].b inside {8'h0A, 8'h0D, 8'h09}) ? 1 : 3)].ch !== dir_tab[i].first) begin
        $error("table first char expected 0x%02h", dir_tab[i].first);
        errors++;
      end
    end
    drain();

    // Limit extremes: zero and tiny; no limit and full scale follow in the phases below.
    cfg_write(REG_LIMIT, 16'd0);
    send_byte(8'h41, 1'b0); send_byte(8'h42, 1'b1);
    drain();
    cfg_write(REG_LIMIT, 16'd3);
    send_byte(8'h41, 1'b0); send_byte(8'h42, 1'b0); send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0); send_byte(8'hAC, 1'b0); send_byte(8'h43, 1'b1);
    send_byte(8'h41, 1'b0); send_byte(8'h42, 1'b0); send_byte(8'h43, 1'b1);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin cfg_write(REG_NOLIM, 16'd1); cfg_write(REG_LIMIT, 16'hFFFF); end
        1: begin cfg_write(REG_NOLIM, 16'd0); cfg_write(REG_LIMIT, 16'd9); end
        2: cfg_write(REG_LIMIT, 16'hFFFF);
        default: cfg_write(REG_LIMIT, 16'd5);
      endcase
      idle_free = (phase == 2);
      for (int k = 0; k < 21; k++) begin
        // The long receiver stall starts while requests keep coming.
        if (phase == 0 && k == 5) hold_go = 1'b1;
        // Mostly well-formed sequences, some noise and cut-off prefixes.
        case ($urandom_range(9))
          0, 1: send_byte(8'($urandom_range(255, 1)), $urandom_range(7) == 0);
          2: begin
            send_byte(8'($urandom_range(8'hDF, 8'hC2)), 1'b0);
            send_byte($urandom_range(3) == 0 ? 8'h85 : rand_cont(), $urandom_range(5) == 0);
          end
          3, 4: begin
            lead = 8'($urandom_range(8'hEF, 8'hE0));
            if ($urandom_range(2) == 0) lead = 8'hE2;
            send_byte(lead, 1'b0);
            send_byte(lead == 8'hE2 ? (8'h80 | 8'($urandom_range(8'h2F, 8'h28))) :
                      rand_cont(), $urandom_range(9) == 0);
            send_byte(rand_cont(), $urandom_range(5) == 0);
          end
          5, 6: begin
            send_byte(8'($urandom_range(8'hF4, 8'hF0)), 1'b0);
            send_byte(rand_cont(), 1'b0);
            send_byte(rand_cont(), $urandom_range(9) == 0);
            send_byte(rand_cont(), $urandom_range(5) == 0);
          end
          default: send_byte(8'($urandom_range(8'h7E, 8'h20)), $urandom_range(9) == 0);
        endcase
        // Sender pauses until every expected character has come.
        if (phase == 1 && k == 20) begin
          in_tvalid <= 1'b0;
          while (expected_chars.size() > 0) @(posedge clk);
        end
      end
      send_byte(8'h2E, 1'b1);
      drain();
    end

    drain();
    if (errors == 0 && expected_chars.size() == 0) begin
      $display("PASS utf8_validating_escape_filter");
    end else begin
      if (expected_chars.size() != 0) $error("%0d characters never came", expected_chars.size());
      $display("FAIL utf8_validating_escape_filter");
    end
    $finish;
  end

endmodule
